// ===== hw/rtl/alfc_pkg.sv =====
// ----------------------------------------------------------------------------
// alfc_pkg
// Types and constants shared by the ascii length frame checker.
// ----------------------------------------------------------------------------
package alfc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned IDX_W     = 14;
   localparam int unsigned LEN_W     = 14;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned HDR_LEN   = 8;
   localparam int unsigned HDR_POS_W = 3;
   localparam int unsigned LEN_POS   = 4;
   localparam int unsigned CHECK_OFF = 2;
   localparam int unsigned IDX_MAX   = (1 << IDX_W) - 1;

   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [BYTE_W-1:0] TAG_CHAR [4] = '{8'h3C, 8'h6D, 8'h73, 8'h67};

   typedef enum logic [STATUS_W-1:0] {
      ST_VALID      = 3'd0,
      ST_TOO_SHORT  = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_CHECK_FAIL = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_buffer;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  frame_length;
      logic [BYTE_W-1:0] computed_sum;
      logic [BYTE_W-1:0] received_check;
   } rsp_type;

endpackage

// ===== hw/rtl/alfc_if.sv =====
// ----------------------------------------------------------------------------
// alfc request and response channels
// Valid/ready channels carrying received bytes in and frame results out.
// ----------------------------------------------------------------------------
interface alfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface alfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [13:0] frame_length;
   logic [7:0]  computed_sum;
   logic [7:0]  received_check;

   modport source (output valid, output status, output frame_length,
                   output computed_sum, output received_check, input ready);
   modport sink   (input valid, input status, input frame_length,
                   input computed_sum, input received_check, output ready);
endinterface

// ===== hw/rtl/alfc_in_reg.sv =====
// ----------------------------------------------------------------------------
// alfc_in_reg
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module alfc_in_reg (
   input  logic               clock,
   input  logic               reset,
   alfc_req_if.sink           req_ch,
   input  logic               take,
   output logic               item_valid,
   output alfc_pkg::req_type  item
);

   logic              valid_ff;
   logic              valid_in;
   alfc_pkg::req_type item_ff;

   assign req_ch.ready = !valid_ff || take;
   assign valid_in     = (req_ch.valid && req_ch.ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.data_byte     <= req_ch.data_byte;
         item_ff.end_of_buffer <= req_ch.end_of_buffer;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/alfc_core.sv =====
// ----------------------------------------------------------------------------
// alfc_core
// Per-byte frame state: header capture, length decode, running checksum
// and the end-of-buffer verdict.
// ----------------------------------------------------------------------------
module alfc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  alfc_pkg::req_type  item,
   input  logic               out_free,
   output logic               take,
   output logic               res_we,
   output alfc_pkg::rsp_type  res
);

   localparam int unsigned BW = alfc_pkg::BYTE_W;
   localparam int unsigned IW = alfc_pkg::IDX_W;
   localparam int unsigned LW = alfc_pkg::LEN_W;
   localparam int unsigned PW = alfc_pkg::HDR_POS_W;

   logic [IW-1:0] idx_ff, idx_in;
   logic [BW-1:0] total_ff, total_in;
   logic [LW-1:0] len_ff, len_in;
   logic          num_ff, num_in;
   logic [BW-1:0] sum_ff, sum_in;
   logic [BW-1:0] chk_ff, chk_in;
   logic [BW-1:0] hdr_ff [alfc_pkg::HDR_LEN];
   logic [BW-1:0] pre_ff [alfc_pkg::HDR_LEN];

   logic [BW-1:0] d;
   logic          in_hdr;
   logic [PW-1:0] pos;
   logic          is_digit;
   logic [3:0]    digit;
   logic [LW-1:0] len_base;
   logic [LW-1:0] len_step;
   logic          num_step;
   logic [BW-1:0] total_base;
   logic          len_ok;
   logic          v_small;
   logic          v_has_chk;
   logic [PW-1:0] chk_pos;
   logic [BW-1:0] chk_sel;
   logic [BW-1:0] pre_sel;
   logic          body_active;
   logic          tag_ok;
   logic          short_buf;

   assign take   = item_valid && (!item.end_of_buffer || out_free);
   assign res_we = take && item.end_of_buffer;

   assign d        = item.data_byte;
   assign in_hdr   = (idx_ff[IW-1:PW] == '0);
   assign pos      = idx_ff[PW-1:0];
   assign is_digit = (d >= alfc_pkg::CHAR_ZERO) && (d <= alfc_pkg::CHAR_NINE);
   assign digit    = d[3:0];

   // length digits accumulate one per byte, times ten by shift and add
   assign len_base = (pos == PW'(alfc_pkg::LEN_POS)) ? '0 : len_ff;
   assign len_step = {len_base[LW-4:0], 3'b000} + {len_base[LW-2:0], 1'b0}
                     + LW'(digit);
   assign num_step = ((pos == PW'(alfc_pkg::LEN_POS)) || num_ff) && is_digit;

   assign total_base = (pos == '0) ? '0 : total_ff;

   // header checksum at the last header byte, from stored prefix sums
   assign len_ok    = num_step && (len_step >= LW'(alfc_pkg::CHECK_OFF));
   assign v_small   = (len_step[LW-1:PW] == '0);
   assign v_has_chk = (len_step <= LW'(alfc_pkg::HDR_LEN + alfc_pkg::CHECK_OFF - 1));
   assign chk_pos   = len_step[PW-1:0] - PW'(alfc_pkg::CHECK_OFF);
   assign chk_sel   = (chk_pos == PW'(alfc_pkg::HDR_LEN - 1)) ? d : hdr_ff[chk_pos];
   // the prefix sum up to byte six is still being formed this cycle
   assign pre_sel   = !v_small ? (total_base + d) :
                      (len_step[PW-1:0] == PW'(alfc_pkg::HDR_LEN - 1)) ? total_base :
                      pre_ff[len_step[PW-1:0]];

   assign body_active = num_ff && (len_ff >= LW'(alfc_pkg::CHECK_OFF));

   always_comb begin
      idx_in   = (idx_ff == IW'(alfc_pkg::IDX_MAX)) ? idx_ff : idx_ff + 1'b1;
      total_in = total_ff;
      len_in   = len_ff;
      num_in   = num_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      if (in_hdr) begin
         total_in = total_base + d;
         if (pos >= PW'(alfc_pkg::LEN_POS)) begin
            len_in = len_step;
            num_in = num_step;
         end
         if (pos == PW'(alfc_pkg::HDR_LEN - 1)) begin
            len_in = num_step ? len_step : '0;
            if (len_ok) begin
               chk_in = v_has_chk ? chk_sel : '0;
               sum_in = pre_sel - (v_has_chk ? chk_sel : '0);
            end else begin
               chk_in = '0;
               sum_in = '0;
            end
         end
      end else if (body_active) begin
         if (idx_ff == len_ff - LW'(alfc_pkg::CHECK_OFF)) begin
            chk_in = d;
         end else if (idx_ff < len_ff) begin
            sum_in = sum_ff + d;
         end
      end
   end

   // verdict from the state as it stands after this byte
   assign short_buf = (idx_in[IW-1:PW] == '0);
   assign tag_ok    = (hdr_ff[0] == alfc_pkg::TAG_CHAR[0]) &&
                      (hdr_ff[1] == alfc_pkg::TAG_CHAR[1]) &&
                      (hdr_ff[2] == alfc_pkg::TAG_CHAR[2]) &&
                      (hdr_ff[3] == alfc_pkg::TAG_CHAR[3]);

   always_comb begin
      res.status         = alfc_pkg::ST_VALID;
      res.frame_length   = '0;
      res.computed_sum   = '0;
      res.received_check = '0;
      if (short_buf) begin
         res.status = alfc_pkg::ST_TOO_SHORT;
      end else begin
         res.frame_length = len_in;
         if (!tag_ok) begin
            res.status = alfc_pkg::ST_BAD_HEADER;
         end else if (!num_in || (len_in < LW'(alfc_pkg::CHECK_OFF)) ||
                      (len_in > idx_in)) begin
            res.status = alfc_pkg::ST_BAD_LENGTH;
         end else begin
            res.computed_sum   = sum_in;
            res.received_check = chk_in;
            res.status = (sum_in == chk_in) ? alfc_pkg::ST_VALID : alfc_pkg::ST_CHECK_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= item.end_of_buffer ? '0 : idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         len_ff   <= '0;
         num_ff   <= 1'b0;
         sum_ff   <= '0;
         chk_ff   <= '0;
      end else if (take) begin
         total_ff <= total_in;
         len_ff   <= len_in;
         num_ff   <= num_in;
         sum_ff   <= sum_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_hdr) begin
         hdr_ff[pos] <= d;
         pre_ff[pos] <= total_base;
      end
   end

   a_idx_clears: assert property (@(posedge clock) disable iff (reset)
      res_we |=> (idx_ff == '0))
      else $error("byte index not cleared after end of buffer");

   a_idx_steps: assert property (@(posedge clock) disable iff (reset)
      (take && !item.end_of_buffer && (idx_ff != IW'(alfc_pkg::IDX_MAX)))
      |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("byte index did not advance");

   a_valid_match: assert property (@(posedge clock) disable iff (reset)
      (res_we && (res.status == alfc_pkg::ST_VALID))
      |-> (res.computed_sum == res.received_check))
      else $error("valid status with checksum mismatch");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      (res_we && (res.status == alfc_pkg::ST_TOO_SHORT))
      |-> ((res.frame_length == '0) && (res.computed_sum == '0)))
      else $error("short buffer reports length or sum");

endmodule

// ===== hw/rtl/alfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// alfc_out_reg
// Result register: holds one frame verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module alfc_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               res_we,
   input  alfc_pkg::rsp_type  res,
   output logic               out_free,
   alfc_rsp_if.source         rsp_ch
);

   logic              valid_ff;
   logic              valid_in;
   alfc_pkg::rsp_type res_ff;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign valid_in = res_we || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_ff <= res;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.status         = res_ff.status;
   assign rsp_ch.frame_length   = res_ff.frame_length;
   assign rsp_ch.computed_sum   = res_ff.computed_sum;
   assign rsp_ch.received_check = res_ff.received_check;

endmodule

// ===== hw/rtl/ascii_length_frame_checker.sv =====
// ----------------------------------------------------------------------------
// ascii_length_frame_checker
// Checks a "<msg" frame with a four-digit ascii length and a byte checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries the received buffer one byte per item, end_of_buffer set
//   on the last byte. Every buffer gives exactly one item on rsp_ch, with
//   status (valid, too short, bad header, bad length, checksum mismatch),
//   the decoded length, the computed sum and the received check byte.
//   Path: a last byte accepted on req_ch passes the input register, then the
//   result register, before rsp_ch.valid rises.
//   Throughput: one byte per cycle while no last byte waits for the result
//   register; each byte is handled by the core between the two registers.
//   Stalls: while a result waits on rsp_ch, bytes that do not end a buffer
//   keep flowing; a last byte waits in the input register until the result
//   register is free, and req_ch.ready drops only then.
//   Reset (synchronous, active high) empties both registers and starts a new
//   buffer; after each result the block is ready for the next buffer.
// ----------------------------------------------------------------------------
module ascii_length_frame_checker (
   input  logic        clock,
   input  logic        reset,
   alfc_req_if.sink    req_ch,
   alfc_rsp_if.source  rsp_ch
);

   logic              item_valid;
   alfc_pkg::req_type item;
   logic              take;
   logic              res_we;
   alfc_pkg::rsp_type res;
   logic              out_free;

   alfc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   alfc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .res_we     (res_we),
      .res        (res)
   );

   alfc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .res_we   (res_we),
      .res      (res),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule
